### design/tsp_pkg.sv
package tsp_pkg;

   // default sizes
   localparam int MAX_TILES_X_DEF   = 64;
   localparam int MAX_TILES_Y_DEF   = 64;
   localparam int HEIGHT_BITS_DEF   = 16;
   localparam int POT_FRAC_BITS_DEF = 12;

   // fixed formats
   localparam int HFRAC       = 8;    // height fraction bits
   localparam int GFRAC       = 12;   // gain fraction bits
   localparam int GAIN_BITS   = 16;
   localparam int TILE_BITS   = 7;
   localparam int SAMPLE_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // root digits resolved per pipeline stage
   localparam int SQRT_STEPS = 4;

   // item opcodes
   localparam logic OP_HEIGHT = 1'b0;
   localparam logic OP_TILE   = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TILES_X   = 3'd0,
      CSR_TILES_Y   = 3'd1,
      CSR_SLOPE_SUL = 3'd2,
      CSR_SLOPE_CRY = 3'd3,
      CSR_FLOW_BIO  = 3'd4,
      CSR_FLOW_HYD  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] sul;
      logic [GAIN_BITS-1:0] cry;
      logic [GAIN_BITS-1:0] bio;
      logic [GAIN_BITS-1:0] hyd;
   } gains_type;

endpackage

### design/tsp_ram.sv
module tsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tsp_isqrt.sv
module tsp_isqrt import tsp_pkg::*; #(
   parameter int RW = 13,
   localparam int TW  = 2 * RW,
   localparam int RMW = RW + 3,
   localparam int NS  = (RW + SQRT_STEPS - 1) / SQRT_STEPS
) (
   input  logic          clock,
   input  logic          en,
   input  logic [TW-1:0] radicand,
   output logic [RW-1:0] root
);

   logic [TW-1:0]  rad_ff  [NS];
   logic [RMW-1:0] rem_ff  [NS];
   logic [RW-1:0]  root_ff [NS];
   logic [TW-1:0]  rad_in  [NS];
   logic [RMW-1:0] rem_in  [NS];
   logic [RW-1:0]  root_in [NS];

   // restoring digit recurrence, SQRT_STEPS digits per stage
   always_comb begin
      logic [TW-1:0]  rad;
      logic [RMW-1:0] rem;
      logic [RW-1:0]  rt;
      logic [RMW-1:0] trial;
      for (int j = 0; j < NS; j++) begin
         if (j == 0) begin
            rad = radicand;
            rem = '0;
            rt  = '0;
         end else begin
            rad = rad_ff[j-1];
            rem = rem_ff[j-1];
            rt  = root_ff[j-1];
         end
         for (int m = 0; m < SQRT_STEPS; m++) begin
            if (j * SQRT_STEPS + m < RW) begin
               rem   = {rem[RMW-3:0], rad[TW-1:TW-2]};
               trial = RMW'({rt, 2'b01});
               if (rem >= trial) begin
                  rem = rem - trial;
                  rt  = {rt[RW-2:0], 1'b1};
               end else begin
                  rt  = {rt[RW-2:0], 1'b0};
               end
               rad = rad << 2;
            end
         end
         rad_in[j]  = rad;
         rem_in[j]  = rem;
         root_in[j] = rt;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NS; j++) begin
            rad_ff[j]  <= rad_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign root = root_ff[NS-1];

endmodule

### design/tsp_update.sv
module tsp_update import tsp_pkg::*; #(
   parameter int POT_FRAC_BITS = POT_FRAC_BITS_DEF,
   localparam int PW  = POT_FRAC_BITS + 1,
   localparam int CVW = POT_FRAC_BITS + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [PW-1:0]         sul_in,
   input  logic [PW-1:0]         cry_in,
   input  logic [PW-1:0]         bio_in,
   input  logic [PW-1:0]         hyd_in,
   input  logic signed [CVW-1:0] curv_in,
   input  logic [PW-1:0]         inflow_in,
   input  logic                  big_in,
   input  logic [PW-1:0]         root_in,
   input  gains_type             gains,
   output logic                  out_valid,
   output logic [PW-1:0]         sul_out,
   output logic [PW-1:0]         cry_out,
   output logic [PW-1:0]         bio_out,
   output logic [PW-1:0]         hyd_out,
   output logic [PW-1:0]         slope_out,
   output logic signed [CVW-1:0] curv_out,
   output logic [PW-1:0]         inflow_out
);

   localparam int ONE  = 1 << POT_FRAC_BITS;
   localparam int THR  = (3 * ONE) / 10;
   localparam int PRW  = PW + GAIN_BITS;
   localparam int SUMW = PRW - GFRAC + 1;
   localparam int FW   = PW + 1;
   localparam int BPW  = PW + FW;

   function automatic logic [PW-1:0] clamp_sum(input logic [SUMW-1:0] v);
      return (v > SUMW'(ONE)) ? PW'(ONE) : PW'(v);
   endfunction

   // stage 1: slope cap and gain products
   logic [PW-1:0]  slope_w, negc_w;
   logic           u1_valid_ff;
   logic [PW-1:0]  u1_sul_ff, u1_cry_ff, u1_bio_ff, u1_hyd_ff;
   logic [PW-1:0]  u1_slope_ff, u1_inflow_ff;
   logic signed [CVW-1:0] u1_curv_ff;
   logic [PRW-1:0] u1_psul_ff, u1_pcry_ff, u1_pbc_ff, u1_phc_ff, u1_pbin_ff, u1_phin_ff;

   always_comb begin
      if (big_in || root_in > PW'(ONE)) begin
         slope_w = PW'(ONE);
      end else begin
         slope_w = root_in;
      end
      negc_w = (curv_in < 0) ? PW'(-curv_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u1_valid_ff <= 1'b0;
      end else if (en) begin
         u1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u1_sul_ff    <= sul_in;
         u1_cry_ff    <= cry_in;
         u1_bio_ff    <= bio_in;
         u1_hyd_ff    <= hyd_in;
         u1_slope_ff  <= slope_w;
         u1_curv_ff   <= curv_in;
         u1_inflow_ff <= inflow_in;
         u1_psul_ff   <= PRW'(slope_w) * PRW'(gains.sul);
         u1_pcry_ff   <= PRW'(slope_w) * PRW'(gains.cry);
         u1_pbc_ff    <= PRW'(negc_w) * PRW'(gains.bio);
         u1_phc_ff    <= PRW'(negc_w) * PRW'(gains.hyd);
         u1_pbin_ff   <= PRW'(inflow_in) * PRW'(gains.bio);
         u1_phin_ff   <= PRW'(inflow_in) * PRW'(gains.hyd);
      end
   end

   // stage 2: accumulate and clamp
   logic [PW-1:0] sul2_w, cry2_w, bio1_w, bio2_w, hyd1_w, hyd2_w;
   logic          peak_w;
   logic [FW-1:0] factor_w;
   logic          u2_valid_ff, u2_peak_ff;
   logic [PW-1:0] u2_sul_ff, u2_cry_ff, u2_bio_ff, u2_hyd_ff, u2_slope_ff, u2_inflow_ff;
   logic [FW-1:0] u2_factor_ff;
   logic signed [CVW-1:0] u2_curv_ff;

   always_comb begin
      sul2_w   = clamp_sum(SUMW'(u1_sul_ff) + SUMW'(u1_psul_ff >> GFRAC));
      cry2_w   = clamp_sum(SUMW'(u1_cry_ff) + SUMW'(u1_pcry_ff >> GFRAC));
      bio1_w   = clamp_sum(SUMW'(u1_bio_ff) + SUMW'(u1_pbc_ff >> GFRAC));
      hyd1_w   = clamp_sum(SUMW'(u1_hyd_ff) + SUMW'(u1_phc_ff >> GFRAC));
      hyd2_w   = clamp_sum(SUMW'(hyd1_w) + SUMW'(u1_phin_ff >> GFRAC));
      // inflow feeds biological at half gain
      bio2_w   = clamp_sum(SUMW'(bio1_w) + SUMW'(u1_pbin_ff >> (GFRAC + 1)));
      peak_w   = (u1_curv_ff > CVW'(THR));
      factor_w = FW'(2 * ONE) - FW'(u1_curv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u2_valid_ff <= 1'b0;
      end else if (en) begin
         u2_valid_ff <= u1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u2_sul_ff    <= sul2_w;
         u2_cry_ff    <= cry2_w;
         u2_bio_ff    <= bio2_w;
         u2_hyd_ff    <= hyd2_w;
         u2_peak_ff   <= peak_w;
         u2_factor_ff <= factor_w;
         u2_slope_ff  <= u1_slope_ff;
         u2_curv_ff   <= u1_curv_ff;
         u2_inflow_ff <= u1_inflow_ff;
      end
   end

   // stage 3: peak reduction into the output register
   logic [BPW-1:0] peak_prod_w;
   logic [PW-1:0]  bio3_w;
   logic           out_valid_ff;
   logic [PW-1:0]  sul_ff, cry_ff, bio_ff, hyd_ff, slope_ff, inflow_ff;
   logic signed [CVW-1:0] curv_ff;

   always_comb begin
      peak_prod_w = BPW'(u2_bio_ff) * BPW'(u2_factor_ff);
      bio3_w      = u2_peak_ff ? PW'(peak_prod_w >> (POT_FRAC_BITS + 1)) : u2_bio_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= u2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sul_ff    <= u2_sul_ff;
         cry_ff    <= u2_cry_ff;
         bio_ff    <= bio3_w;
         hyd_ff    <= u2_hyd_ff;
         slope_ff  <= u2_slope_ff;
         curv_ff   <= u2_curv_ff;
         inflow_ff <= u2_inflow_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign sul_out    = sul_ff;
   assign cry_out    = cry_ff;
   assign bio_out    = bio_ff;
   assign hyd_out    = hyd_ff;
   assign slope_out  = slope_ff;
   assign curv_out   = curv_ff;
   assign inflow_out = inflow_ff;

endmodule

### design/terrain_stencil_potential_update.sv
// channel   direction  handshake                payload
// req_      in         req_valid / req_stall    op, col, row, height sample, four potentials
// rsp_      out        rsp_valid / rsp_stall    four potentials, slope, curvature, inflow
// csr_      in         csr_valid / csr_ready    register index, write data
//
// one item enters per cycle while req_stall is low; a tile result passes the store read,
// stages B, C and D, the root pipeline and the update stages before it leaves
// height writes give no result and take effect for the very next item
// reset clears valid bits and config registers; the height store holds garbage until written
// the whole pipeline halts while a result waits under rsp_stall; req_stall follows it
module terrain_stencil_potential_update import tsp_pkg::*; #(
   parameter int MAX_TILES_X   = MAX_TILES_X_DEF,
   parameter int MAX_TILES_Y   = MAX_TILES_Y_DEF,
   parameter int HEIGHT_BITS   = HEIGHT_BITS_DEF,
   parameter int POT_FRAC_BITS = POT_FRAC_BITS_DEF,
   localparam int PW  = POT_FRAC_BITS + 1,
   localparam int CVW = POT_FRAC_BITS + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   // item input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic [TILE_BITS-1:0]      req_col,
   input  logic [TILE_BITS-1:0]      req_row,
   input  logic signed [SAMPLE_BITS-1:0] req_height_sample,
   input  logic [PW-1:0]             req_sulfide_in,
   input  logic [PW-1:0]             req_crystalline_in,
   input  logic [PW-1:0]             req_biological_in,
   input  logic [PW-1:0]             req_hydrological_in,
   // results
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [PW-1:0]             rsp_sulfide_out,
   output logic [PW-1:0]             rsp_crystalline_out,
   output logic [PW-1:0]             rsp_biological_out,
   output logic [PW-1:0]             rsp_hydrological_out,
   output logic [PW-1:0]             rsp_slope,
   output logic signed [CVW-1:0]     rsp_curvature,
   output logic [PW-1:0]             rsp_inflow,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int HB    = HEIGHT_BITS;
   localparam int PITCH = MAX_TILES_X + 1;
   localparam int DEPTH = (MAX_TILES_X + 1) * (MAX_TILES_Y + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int ONE   = 1 << POT_FRAC_BITS;
   localparam int TSW   = 10;
   localparam int LIM   = 1 << (HFRAC + 2);
   localparam int DW    = HFRAC + 3;           // height difference once known small
   localparam int SQW   = 2 * DW;
   localparam int SW    = SQW + 1;
   localparam int LW    = HB + 3;              // laplacian
   localparam int FW    = HB + 2;              // inflow sum
   localparam int RW    = POT_FRAC_BITS + 1;   // root width
   localparam int TW    = 2 * RW;
   localparam int NS    = (RW + SQRT_STEPS - 1) / SQRT_STEPS;
   // scale of heights into potentials
   localparam int DSH   = POT_FRAC_BITS - HFRAC - 2;
   localparam int DP    = (DSH > 0) ? DSH : 0;
   localparam int DN    = (DSH < 0) ? -DSH : 0;
   localparam int CW0   = LW + DP;
   localparam int CW    = (CW0 > POT_FRAC_BITS + 3) ? CW0 : POT_FRAC_BITS + 3;
   localparam int IW0   = FW + DP;
   localparam int IW    = (IW0 > POT_FRAC_BITS + 2) ? IW0 : POT_FRAC_BITS + 2;
   // root input shift
   localparam int KSH   = 2 * POT_FRAC_BITS - 2 * (HFRAC + 2);
   localparam int KP    = (KSH > 0) ? KSH : 0;
   localparam int KN    = (KSH < 0) ? -KSH : 0;
   localparam int EXW   = SW + KP;
   // height store banks
   localparam int TAP_C = 0;
   localparam int TAP_L = 1;
   localparam int TAP_R = 2;
   localparam int TAP_U = 3;
   localparam int TAP_D = 4;
   localparam int TAPS  = 5;

   // whole pipeline moves unless a result is held back
   logic en;
   logic accept;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // ---------------- configuration registers ----------------
   logic [TILE_BITS-1:0] tiles_x_ff, tiles_y_ff;
   gains_type            gains_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tiles_x_ff <= TILE_BITS'(64);
         tiles_y_ff <= TILE_BITS'(64);
         gains_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TILES_X:   tiles_x_ff   <= csr_data[TILE_BITS-1:0];
            CSR_TILES_Y:   tiles_y_ff   <= csr_data[TILE_BITS-1:0];
            CSR_SLOPE_SUL: gains_ff.sul <= csr_data;
            CSR_SLOPE_CRY: gains_ff.cry <= csr_data;
            CSR_FLOW_BIO:  gains_ff.bio <= csr_data;
            CSR_FLOW_HYD:  gains_ff.hyd <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // ---------------- stage 0: addressing and store access ----------------
   logic [TSW-1:0] tx_sat, ty_sat;
   logic           edge_tile;
   logic [AW-1:0]  center_addr, wr_addr;
   logic           wr_en;
   logic [HB-1:0]  wr_height;
   logic [AW-1:0]  rd_addr [TAPS];
   logic [HB-1:0]  rd_data [TAPS];

   always_comb begin
      tx_sat = (32'(tiles_x_ff) > MAX_TILES_X) ? TSW'(MAX_TILES_X) : TSW'(tiles_x_ff);
      ty_sat = (32'(tiles_y_ff) > MAX_TILES_Y) ? TSW'(MAX_TILES_Y) : TSW'(tiles_y_ff);
      // last column or row has no full stencil
      edge_tile = !((TSW'(req_col) + TSW'(2) <= tx_sat) && (TSW'(req_row) + TSW'(2) <= ty_sat));
      center_addr = AW'((32'(req_row) + 32'd1) * 32'(PITCH) + 32'(req_col) + 32'd1);
      if (edge_tile) begin
         for (int t = 0; t < TAPS; t++) begin
            rd_addr[t] = '0;
         end
      end else begin
         rd_addr[TAP_C] = center_addr;
         rd_addr[TAP_L] = center_addr - AW'(1);
         rd_addr[TAP_R] = center_addr + AW'(1);
         rd_addr[TAP_U] = center_addr - AW'(PITCH);
         rd_addr[TAP_D] = center_addr + AW'(PITCH);
      end
      wr_addr   = AW'(32'(req_row) * 32'(PITCH) + 32'(req_col));
      wr_en     = accept && (req_op == OP_HEIGHT) &&
                  (32'(req_col) <= MAX_TILES_X) && (32'(req_row) <= MAX_TILES_Y);
      // wraps to the store width, two's complement
      wr_height = HB'(req_height_sample);
   end

   // one copy of the store per stencil tap, all written together
   for (genvar g = 0; g < TAPS; g++) begin : g_bank
      tsp_ram #(
         .WIDTH (HB),
         .DEPTH (DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_height),
         .rd_en   (en),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   // stage A payload, aligned with the store read data
   logic               a_valid_ff, a_edge_ff;
   logic [3:0][PW-1:0] a_pots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= accept && (req_op == OP_TILE);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_edge_ff <= edge_tile;
         a_pots_ff <= {req_hydrological_in, req_biological_in,
                       req_crystalline_in, req_sulfide_in};
      end
   end

   // ---------------- stage B: differences ----------------
   logic signed [HB-1:0] h_w [TAPS];
   logic signed [HB:0]   dx_w, dz_w, nd_w;
   logic signed [LW-1:0] lap_w;
   logic [FW-1:0]        fin_w;
   logic                 big_w;

   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         h_w[t] = $signed(rd_data[t]);
      end
      dx_w  = (HB+1)'(h_w[TAP_R]) - (HB+1)'(h_w[TAP_L]);
      dz_w  = (HB+1)'(h_w[TAP_D]) - (HB+1)'(h_w[TAP_U]);
      lap_w = LW'(h_w[TAP_L]) + LW'(h_w[TAP_R]) + LW'(h_w[TAP_U]) + LW'(h_w[TAP_D])
              - (LW'(h_w[TAP_C]) <<< 2);
      // excess of the higher neighbours
      fin_w = '0;
      for (int t = TAP_L; t < TAPS; t++) begin
         nd_w = (HB+1)'(h_w[t]) - (HB+1)'(h_w[TAP_C]);
         if (nd_w > 0) begin
            fin_w = fin_w + FW'(nd_w[HB-1:0]);
         end
      end
      big_w = (dx_w >= LIM) || (dx_w <= -LIM) || (dz_w >= LIM) || (dz_w <= -LIM);
   end

   logic                 b_valid_ff, b_big_ff;
   logic signed [DW-1:0] b_dx_ff, b_dz_ff;
   logic signed [LW-1:0] b_lap_ff;
   logic [FW-1:0]        b_fin_ff;
   logic [3:0][PW-1:0]   b_pots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_pots_ff <= a_pots_ff;
         if (a_edge_ff) begin
            // edge tile: all measures zero
            b_dx_ff  <= '0;
            b_dz_ff  <= '0;
            b_lap_ff <= '0;
            b_fin_ff <= '0;
            b_big_ff <= 1'b0;
         end else begin
            b_dx_ff  <= DW'(dx_w);
            b_dz_ff  <= DW'(dz_w);
            b_lap_ff <= lap_w;
            b_fin_ff <= fin_w;
            b_big_ff <= big_w;
         end
      end
   end

   // ---------------- stage C: squares, curvature, inflow ----------------
   logic signed [SQW-1:0] sqx_w, sqy_w;
   logic signed [CW-1:0]  lap_x, lap_bias, curv_x;
   logic signed [CVW-1:0] curv_w;
   logic [IW-1:0]         fin_x;
   logic [PW-1:0]         inflow_w;

   always_comb begin
      sqx_w = b_dx_ff * b_dx_ff;
      sqy_w = b_dz_ff * b_dz_ff;
      // scale toward zero, then clamp to plus or minus one
      lap_x    = CW'(b_lap_ff);
      lap_bias = (lap_x < 0) ? CW'((1 << DN) - 1) : '0;
      curv_x   = ((lap_x + lap_bias) >>> DN) <<< DP;
      if (curv_x > CW'(ONE)) begin
         curv_w = CVW'(ONE);
      end else if (curv_x < CW'(-ONE)) begin
         curv_w = CVW'(-ONE);
      end else begin
         curv_w = CVW'(curv_x);
      end
      fin_x    = (IW'(b_fin_ff) >> DN) << DP;
      inflow_w = (fin_x > IW'(ONE)) ? PW'(ONE) : PW'(fin_x);
   end

   logic                  c_valid_ff, c_big_ff;
   logic [SQW-1:0]        c_sqx_ff, c_sqy_ff;
   logic signed [CVW-1:0] c_curv_ff;
   logic [PW-1:0]         c_inflow_ff;
   logic [3:0][PW-1:0]    c_pots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_sqx_ff    <= unsigned'(sqx_w);
         c_sqy_ff    <= unsigned'(sqy_w);
         c_curv_ff   <= curv_w;
         c_inflow_ff <= inflow_w;
         c_big_ff    <= b_big_ff;
         c_pots_ff   <= b_pots_ff;
      end
   end

   // ---------------- stage D: root operand ----------------
   logic [SW-1:0]  sum_sq_w;
   logic [EXW-1:0] sum_ext_w;
   logic [TW-1:0]  radicand_w;

   always_comb begin
      sum_sq_w   = SW'(c_sqx_ff) + SW'(c_sqy_ff);
      sum_ext_w  = (EXW'(sum_sq_w) << KP) >> KN;
      radicand_w = TW'(sum_ext_w);
   end

   logic                  d_valid_ff, d_big_ff;
   logic [TW-1:0]         d_radicand_ff;
   logic signed [CVW-1:0] d_curv_ff;
   logic [PW-1:0]         d_inflow_ff;
   logic [3:0][PW-1:0]    d_pots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_radicand_ff <= radicand_w;
         d_curv_ff     <= c_curv_ff;
         d_inflow_ff   <= c_inflow_ff;
         d_big_ff      <= c_big_ff;
         d_pots_ff     <= c_pots_ff;
      end
   end

   // ---------------- root pipeline and its side payload ----------------
   logic [RW-1:0] root_w;

   tsp_isqrt #(
      .RW (RW)
   ) u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (d_radicand_ff),
      .root     (root_w)
   );

   logic                  dl_valid_ff  [NS];
   logic                  dl_big_ff    [NS];
   logic signed [CVW-1:0] dl_curv_ff   [NS];
   logic [PW-1:0]         dl_inflow_ff [NS];
   logic [3:0][PW-1:0]    dl_pots_ff   [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            dl_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         dl_valid_ff[0] <= d_valid_ff;
         for (int k = 1; k < NS; k++) begin
            dl_valid_ff[k] <= dl_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_big_ff[0]    <= d_big_ff;
         dl_curv_ff[0]   <= d_curv_ff;
         dl_inflow_ff[0] <= d_inflow_ff;
         dl_pots_ff[0]   <= d_pots_ff;
         for (int k = 1; k < NS; k++) begin
            dl_big_ff[k]    <= dl_big_ff[k-1];
            dl_curv_ff[k]   <= dl_curv_ff[k-1];
            dl_inflow_ff[k] <= dl_inflow_ff[k-1];
            dl_pots_ff[k]   <= dl_pots_ff[k-1];
         end
      end
   end

   // ---------------- potential update and output register ----------------
   tsp_update #(
      .POT_FRAC_BITS (POT_FRAC_BITS)
   ) u_update (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (dl_valid_ff[NS-1]),
      .sul_in     (dl_pots_ff[NS-1][0]),
      .cry_in     (dl_pots_ff[NS-1][1]),
      .bio_in     (dl_pots_ff[NS-1][2]),
      .hyd_in     (dl_pots_ff[NS-1][3]),
      .curv_in    (dl_curv_ff[NS-1]),
      .inflow_in  (dl_inflow_ff[NS-1]),
      .big_in     (dl_big_ff[NS-1]),
      .root_in    (root_w),
      .gains      (gains_ff),
      .out_valid  (rsp_valid),
      .sul_out    (rsp_sulfide_out),
      .cry_out    (rsp_crystalline_out),
      .bio_out    (rsp_biological_out),
      .hyd_out    (rsp_hydrological_out),
      .slope_out  (rsp_slope),
      .curv_out   (rsp_curvature),
      .inflow_out (rsp_inflow)
   );

endmodule

### design/tsp_checker.sv
module tsp_checker import tsp_pkg::*; #(
   parameter int POT_FRAC_BITS = POT_FRAC_BITS_DEF,
   localparam int PW  = POT_FRAC_BITS + 1,
   localparam int CVW = POT_FRAC_BITS + 2
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [PW-1:0]         rsp_sulfide_out,
   input logic [PW-1:0]         rsp_biological_out,
   input logic [PW-1:0]         rsp_slope,
   input logic signed [CVW-1:0] rsp_curvature
);

   localparam int ONE = 1 << POT_FRAC_BITS;
   localparam int THR = (3 * ONE) / 10;

   // held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slope) &&
         $stable(rsp_curvature) && $stable(rsp_sulfide_out) && $stable(rsp_biological_out))
      else $error("held result changed");

   // input side only stalls behind a blocked result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

   // peak reduction always pulls biological below one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_curvature > CVW'(THR)) |-> rsp_biological_out < PW'(ONE))
      else $error("peak reduction missing");

endmodule

bind terrain_stencil_potential_update tsp_checker #(
   .POT_FRAC_BITS (POT_FRAC_BITS)
) u_tsp_checker (.*);
